### rtl/poset_closure_matrix_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the poset closure matrix block
// Each macro expands to a concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POSET_CLOSURE_MATRIX_ASSERT_SVH
`define POSET_CLOSURE_MATRIX_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define PCM_ASSERT_IMPL(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("poset_closure_matrix: assertion failed");
// Next-cycle implication, disabled while reset is active.
`define PCM_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("poset_closure_matrix: assertion failed");
`else
`define PCM_ASSERT_IMPL(name, clk, rstn, pre, post)
`define PCM_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif

`endif

### rtl/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types, field widths and defaults of the poset closure matrix block.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int DEF_ELEMENTS = 32;
    localparam int DEF_SLOTS    = 4;

    localparam int OPCODE_W  = 3;
    localparam int SLOT_W    = 2;
    localparam int ELEM_W    = 5;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE = 3'd0,
        OP_DELETE = 3'd1,
        OP_COPY   = 3'd2,
        OP_ADD    = 3'd3,
        OP_REMOVE = 3'd4,
        OP_QUERY  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_X,
        ST_READ_Y,
        ST_SWEEP,
        ST_DRAIN,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_X,
        RD_Y,
        RD_SWEEP
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_row_x;
        logic    cap_row_y;
        logic    sweep_start;
        logic    sweep_step;
        logic    ok_load;
        logic    ok_val;
        logic    valid_set;
        logic    valid_clr;
        logic    fix_write;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic slot_in;
        logic src_in;
        logic slot_valid;
        logic src_valid;
        logic same_slot;
        logic elems_in;
        logic x_ne_y;
        logic bit_xy;
        logic bit_yx;
        logic sweep_last;
        logic direct;
        logic out_free;
    } status_t;

endpackage

### rtl/poset_closure_matrix.sv
// ----------------------------------------------------------------------------
// poset_closure_matrix
// Bank of partial orders kept as transitive-closure bit matrices in slots.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------
//  s_      | input     | s_tvalid / s_tready | command transaction, 24-bit tdata
//  m_      | output    | m_tvalid / m_tready | result transaction, 8-bit tdata
//
// Delete, copy onto itself and commands that fail their first checks load the
// result register straight from decode; a query or an add that finds the pair
// present loads it after reading row x, and an add that finds the reverse pair
// after reading row y. Create and copy walk every row; remove reads row x and
// add rows x and y before their walk. The next command is accepted after that load.
// The walk over the slot's rows, one row per cycle through the single read
// port of the row memory, makes create, copy, remove and add the long commands.
// Reset is synchronous and active low; it clears all slot valid marks and
// the sequencer. The row memory is not cleared.
// A stalled result holds in the output register; a new command is already
// accepted while it waits and finishes up to the point of loading its result.
//
// The controller (pcm_ctrl) sequences each command; the datapath (pcm_dp)
// holds the captured fields, the valid marks, the relation rows in a RAM
// indexed by {slot, row}, and the result register. Adding x<y first reads
// rows x and y to reject pairs already ordered, then walks every row and ORs
// row y into each row that holds x. Removing x<y reads row x, walks every row
// looking for an element strictly between x and y, then clears one bit.
// ----------------------------------------------------------------------------
module poset_closure_matrix #(
    parameter int ELEMENTS = pcm_pkg::DEF_ELEMENTS,
    parameter int SLOTS    = pcm_pkg::DEF_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Command transaction.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from the lowest: opcode[2:0], slot[4:3], source_slot[6:5],
    // first_element[11:7], second_element[16:12], zero fill up to bit 23.
    input  logic [pcm_pkg::S_TDATA_W-1:0] s_tdata,
    // Result transaction.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from the lowest: ok[0], zero fill up to bit 7.
    output logic [pcm_pkg::M_TDATA_W-1:0] m_tdata
);
    import pcm_pkg::*;

    // Command and status buses between the sequencer and the datapath.
    cmd_t    cmd;
    status_t status;

    pcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcm_dp #(
        .ELEMENTS (ELEMENTS),
        .SLOTS    (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### rtl/pcm_ram.sv
// ----------------------------------------------------------------------------
// pcm_ram
// Generic RAM with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/pcm_ctrl.sv
// ----------------------------------------------------------------------------
// pcm_ctrl
// Command sequencer: decodes the captured transaction and steps the datapath
// through its checks, the row walk and the result hand-off.
// ----------------------------------------------------------------------------
module pcm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pcm_pkg::status_t  status,
    output pcm_pkg::cmd_t     cmd
);
    import pcm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_X;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                // Failing checks fall through to a zero result.
                cmd.ok_load = 1'b1;
                cmd.ok_val  = 1'b0;
                state_next  = ST_DONE;
                if (status.slot_in) begin
                    unique case (status.op)
                        OP_CREATE: begin
                            if (!status.slot_valid) begin
                                cmd.ok_load     = 1'b0;
                                cmd.sweep_start = 1'b1;
                                state_next      = ST_SWEEP;
                            end
                        end
                        OP_DELETE: begin
                            cmd.ok_val    = status.slot_valid;
                            cmd.valid_clr = 1'b1;
                        end
                        OP_COPY: begin
                            if (status.src_in && status.src_valid) begin
                                if (status.same_slot) begin
                                    cmd.ok_val    = 1'b1;
                                    cmd.valid_set = 1'b1;
                                end else begin
                                    cmd.ok_load     = 1'b0;
                                    cmd.sweep_start = 1'b1;
                                    state_next      = ST_SWEEP;
                                end
                            end
                        end
                        OP_ADD, OP_REMOVE: begin
                            if (status.elems_in && status.x_ne_y && status.slot_valid) begin
                                cmd.ok_load = 1'b0;
                                cmd.rd_en   = 1'b1;
                                cmd.rd_sel  = RD_X;
                                state_next  = ST_READ_X;
                            end
                        end
                        OP_QUERY: begin
                            if (status.elems_in && status.slot_valid) begin
                                cmd.ok_load = 1'b0;
                                cmd.rd_en   = 1'b1;
                                cmd.rd_sel  = RD_X;
                                state_next  = ST_READ_X;
                            end
                        end
                        default: begin
                            cmd.ok_val = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ_X: begin
                cmd.ok_load = 1'b1;
                cmd.ok_val  = 1'b0;
                state_next  = ST_DONE;
                unique case (status.op)
                    OP_QUERY: begin
                        cmd.ok_val = status.bit_xy;
                    end
                    OP_REMOVE: begin
                        if (status.bit_xy) begin
                            cmd.ok_load     = 1'b0;
                            cmd.cap_row_x   = 1'b1;
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                    end
                    OP_ADD: begin
                        if (!status.bit_xy) begin
                            cmd.ok_load = 1'b0;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RD_Y;
                            state_next  = ST_READ_Y;
                        end
                    end
                    default: begin
                        cmd.ok_val = 1'b0;
                    end
                endcase
            end
            ST_READ_Y: begin
                if (status.bit_yx) begin
                    cmd.ok_load = 1'b1;
                    cmd.ok_val  = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    cmd.cap_row_y   = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = RD_SWEEP;
                if (status.sweep_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.op == OP_REMOVE) begin
                    state_next = ST_FIX;
                end else begin
                    cmd.ok_load   = 1'b1;
                    cmd.ok_val    = 1'b1;
                    cmd.valid_set = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_FIX: begin
                cmd.fix_write = status.direct;
                cmd.ok_load   = 1'b1;
                cmd.ok_val    = status.direct;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/pcm_dp.sv
// ----------------------------------------------------------------------------
// pcm_dp
// Datapath: command registers, slot valid marks, the relation row memory,
// the row walk pipeline and the result register.
// ----------------------------------------------------------------------------
`include "poset_closure_matrix_assert.svh"

module pcm_dp #(
    parameter int ELEMENTS = pcm_pkg::DEF_ELEMENTS,
    parameter int SLOTS    = pcm_pkg::DEF_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pcm_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pcm_pkg::M_TDATA_W-1:0] m_tdata,
    input  pcm_pkg::cmd_t                 cmd,
    output pcm_pkg::status_t              status
);
    import pcm_pkg::*;

    localparam int EW    = $clog2(ELEMENTS);
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW    = SW + EW;
    localparam int DEPTH = 1 << AW;

    localparam int OP_LO  = 0;
    localparam int SL_LO  = OP_LO + OPCODE_W;
    localparam int SR_LO  = SL_LO + SLOT_W;
    localparam int X_LO   = SR_LO + SLOT_W;
    localparam int Y_LO   = X_LO + ELEM_W;

    logic [OPCODE_W-1:0] op_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   src_reg;
    logic [ELEM_W-1:0]   x_reg;
    logic [ELEM_W-1:0]   y_reg;
    logic [ELEMENTS-1:0] row_x_reg;
    logic [ELEMENTS-1:0] row_y_reg;
    logic [EW-1:0]       cnt_reg;
    logic                pend_reg;
    logic [EW-1:0]       pend_idx_reg;
    logic                direct_reg;
    logic                ok_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic                out_valid_reg;
    logic                out_ok_reg;

    logic [SW-1:0]       sidx;
    logic [SW-1:0]       ridx;
    logic [EW-1:0]       xidx;
    logic [EW-1:0]       yidx;
    logic [SW-1:0]       sweep_sidx;
    op_t                 op;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [ELEMENTS-1:0] ram_wr_data;
    logic [AW-1:0]       ram_rd_addr;
    logic [ELEMENTS-1:0] ram_rd_data;

    assign op   = op_t'(op_reg);
    assign sidx = SW'(slot_reg);
    assign ridx = SW'(src_reg);
    assign xidx = EW'(x_reg);
    assign yidx = EW'(y_reg);
    assign sweep_sidx = (op == OP_COPY) ? ridx : sidx;

    // Command capture and slot valid marks.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_tdata[SL_LO-1:OP_LO];
            slot_reg <= s_tdata[SR_LO-1:SL_LO];
            src_reg  <= s_tdata[X_LO-1:SR_LO];
            x_reg    <= s_tdata[Y_LO-1:X_LO];
            y_reg    <= s_tdata[Y_LO+ELEM_W-1:Y_LO];
        end
        if (cmd.cap_row_x) begin
            row_x_reg <= ram_rd_data;
        end
        if (cmd.cap_row_y) begin
            row_y_reg <= ram_rd_data;
        end
        if (cmd.ok_load) begin
            ok_reg <= cmd.ok_val;
        end
        if (cmd.out_load) begin
            out_ok_reg <= ok_reg;
        end
        if (cmd.sweep_step) begin
            pend_idx_reg <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            direct_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.valid_set) begin
                valid_reg[sidx] <= 1'b1;
            end else if (cmd.valid_clr) begin
                valid_reg[sidx] <= 1'b0;
            end
            if (cmd.sweep_start) begin
                cnt_reg    <= '0;
                direct_reg <= 1'b1;
            end else if (cmd.sweep_step) begin
                cnt_reg <= cnt_reg + EW'(1);
            end
            pend_reg <= cmd.sweep_step;
            // An intermediate element between x and y blocks a removal.
            if (pend_reg && (op == OP_REMOVE) && (pend_idx_reg != xidx) &&
                (pend_idx_reg != yidx) && row_x_reg[pend_idx_reg] &&
                ram_rd_data[yidx]) begin
                direct_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Row walk: the row read in one cycle is written back in the next.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = {sidx, pend_idx_reg};
        ram_wr_data = ram_rd_data;
        if (cmd.fix_write) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {sidx, xidx};
            ram_wr_data = row_x_reg & ~(ELEMENTS'(1) << yidx);
        end else if (pend_reg) begin
            unique case (op)
                OP_CREATE: begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ELEMENTS'(1) << pend_idx_reg;
                end
                OP_COPY: begin
                    ram_wr_en = 1'b1;
                end
                OP_ADD: begin
                    ram_wr_en   = ram_rd_data[xidx];
                    ram_wr_data = ram_rd_data | row_y_reg;
                end
                default: begin
                    ram_wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_X:     ram_rd_addr = {sidx, xidx};
            RD_Y:     ram_rd_addr = {sidx, yidx};
            RD_SWEEP: ram_rd_addr = {sweep_sidx, cnt_reg};
            default:  ram_rd_addr = {sidx, xidx};
        endcase
    end

    pcm_ram #(
        .WIDTH (ELEMENTS),
        .DEPTH (DEPTH)
    ) u_rows (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        status.op         = op;
        status.slot_in    = (32'(slot_reg) < SLOTS);
        status.src_in     = (32'(src_reg) < SLOTS);
        status.slot_valid = valid_reg[sidx];
        status.src_valid  = valid_reg[ridx];
        status.same_slot  = (slot_reg == src_reg);
        status.elems_in   = (32'(x_reg) < ELEMENTS) && (32'(y_reg) < ELEMENTS);
        status.x_ne_y     = (x_reg != y_reg);
        status.bit_xy     = ram_rd_data[yidx];
        status.bit_yx     = ram_rd_data[xidx];
        status.sweep_last = (cnt_reg == EW'(ELEMENTS - 1));
        status.direct     = direct_reg;
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 1)'(0), out_ok_reg};

    // A row is never read and written at the same address in one cycle.
    `PCM_ASSERT_IMPL(a_no_rw_collision, aclk, aresetn, ram_wr_en && cmd.rd_en, ram_wr_addr != ram_rd_addr)
    // A waiting result is never overwritten.
    `PCM_ASSERT_IMPL(a_out_hold, aclk, aresetn, out_valid_reg && !m_tready, !cmd.out_load)
    // No row write is still pending when a new command is taken.
    `PCM_ASSERT_IMPL(a_idle_no_pend, aclk, aresetn, cmd.capture, !pend_reg)
    // The removal write only follows the drained row walk.
    `PCM_ASSERT_IMPL(a_fix_after_drain, aclk, aresetn, cmd.fix_write, !pend_reg && !cmd.sweep_step)
    // The last walk step leaves exactly one row in flight.
    `PCM_ASSERT_NEXT(a_last_pend, aclk, aresetn, cmd.sweep_step && status.sweep_last, pend_reg && !cmd.sweep_step)

endmodule
